FILE: sv/dpc_pkg.sv
// Dose pump controller package: configuration and queue types, event and
// operation codes, reply byte constants and register reset values.
// No dependencies.
package dpc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int LEVEL_W     = 11;
    localparam int DOSE_W      = 8;
    localparam int PPU_W       = 3;
    localparam int DEB_W       = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_FULL_LEVEL       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALERT_LEVEL      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_BAND       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MID_BAND         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DOSE         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIODS_PER_UNIT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_SAMPLES = 3'd6;

    localparam logic [LEVEL_W-1:0] RST_FULL_LEVEL       = 11'd1500;
    localparam logic [LEVEL_W-1:0] RST_ALERT_LEVEL      = 11'd125;
    localparam logic [LEVEL_W-1:0] RST_EMPTY_BAND       = 11'd125;
    localparam logic [LEVEL_W-1:0] RST_MID_BAND         = 11'd625;
    localparam logic [DOSE_W-1:0]  RST_MAX_DOSE         = 8'h7D;
    localparam logic [PPU_W-1:0]   RST_PERIODS_PER_UNIT = 3'd2;
    localparam logic [DEB_W-1:0]   RST_DEBOUNCE_SAMPLES = 3'd5;
    localparam logic [LEVEL_W-1:0] RST_RESERVOIR        = 11'd1500;

    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_PERIOD = 2'd1;
    localparam logic [1:0] CMD_DUTY   = 2'd2;
    localparam logic [1:0] CMD_SAMPLE = 2'd3;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_DOSE   = 3'd1;
    localparam logic [2:0] OP_STATUS = 3'd2;
    localparam logic [2:0] OP_PERIOD = 3'd3;
    localparam logic [2:0] OP_DUTY   = 3'd4;
    localparam logic [2:0] OP_SAMPLE = 3'd5;

    localparam logic [7:0] RX_STATUS_REQ = 8'hFF;
    localparam logic [7:0] TX_ALERT      = 8'hFF;
    localparam logic [7:0] TX_IDLE_HIGH  = 8'h01;
    localparam logic [7:0] TX_IDLE_MID   = 8'h02;
    localparam logic [7:0] TX_IDLE_LOW   = 8'h03;
    localparam logic [7:0] TX_BUSY_HIGH  = 8'h88;
    localparam logic [7:0] TX_BUSY_MID   = 8'h89;
    localparam logic [7:0] TX_BUSY_LOW   = 8'h8A;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic [LEVEL_W-1:0] full_level;
        logic [LEVEL_W-1:0] alert_level;
        logic [LEVEL_W-1:0] empty_band;
        logic [LEVEL_W-1:0] mid_band;
        logic [DOSE_W-1:0]  max_dose;
        logic [PPU_W-1:0]   periods_per_unit;
        logic [DEB_W-1:0]   debounce_samples;
    } cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       pin;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: sv/dpc_if.sv
// Channel interfaces of the dose pump controller: event input, result
// output and configuration write. Depends on dpc_pkg.
interface dpc_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic       button_level;

    modport source (output valid, command, rx_byte, button_level, input ready);
    modport sink (input valid, command, rx_byte, button_level, output ready);
endinterface

interface dpc_result_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       pump_on;

    modport source (output valid, tx_valid, tx_byte, pump_on, input ready);
    modport sink (input valid, tx_valid, tx_byte, pump_on, output ready);
endinterface

interface dpc_cfg_if;
    import dpc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/dose_pump_controller.sv
// Dose pump controller top level: configuration registers, front end,
// operation queue and back end. Depends on dpc_pkg, dpc_if, dpc_front,
// dpc_queue and dpc_back.
//
//   channel  role   payload                              transaction
//   cmd      sink   command, rx_byte, button_level       one event
//   res      source tx_valid, tx_byte, pump_on           one result per event
//   cfg      sink   index, data                          one register write
//
// One event per cycle sustained while res takes its results; each accepted
// event is written to the queue, then its result to the result register.
// Reset: asynchronous, active low; registers load their defaults and the
// queue empties. Stalls on res back up into the two-entry queue; cmd.ready
// drops only when the queue is full. cfg is always ready.
module dose_pump_controller #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    dpc_event_if.sink    cmd,
    dpc_result_if.source res,
    dpc_cfg_if.sink      cfg
);
    import dpc_pkg::*;

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    op_t                    front_op;
    op_t                    head_op;
    queue_status_t          q_stat;
    logic                   push;
    logic                   pop;
    logic [QUEUE_CNT_W-1:0] q_count;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_FULL_LEVEL:       cfg_next.full_level       = cfg.data;
                REG_ALERT_LEVEL:      cfg_next.alert_level      = cfg.data;
                REG_EMPTY_BAND:       cfg_next.empty_band       = cfg.data;
                REG_MID_BAND:         cfg_next.mid_band         = cfg.data;
                REG_MAX_DOSE:         cfg_next.max_dose         = cfg.data[DOSE_W-1:0];
                REG_PERIODS_PER_UNIT: cfg_next.periods_per_unit = cfg.data[PPU_W-1:0];
                REG_DEBOUNCE_SAMPLES: cfg_next.debounce_samples = cfg.data[DEB_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_level       <= RST_FULL_LEVEL;
            cfg_reg.alert_level      <= RST_ALERT_LEVEL;
            cfg_reg.empty_band       <= RST_EMPTY_BAND;
            cfg_reg.mid_band         <= RST_MID_BAND;
            cfg_reg.max_dose         <= RST_MAX_DOSE;
            cfg_reg.periods_per_unit <= RST_PERIODS_PER_UNIT;
            cfg_reg.debounce_samples <= RST_DEBOUNCE_SAMPLES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dpc_front u_front (
        .cmd     (cmd),
        .cfg_val (cfg_reg),
        .q_stat  (q_stat),
        .push    (push),
        .op      (front_op)
    );

    dpc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (front_op),
        .pop     (pop),
        .head_op (head_op),
        .q_stat  (q_stat),
        .count   (q_count)
    );

    dpc_back #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_val (cfg_reg),
        .op      (head_op),
        .q_stat  (q_stat),
        .pop     (pop),
        .res     (res)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!q_stat.empty && (!res.valid || res.ready)))
        else $error("pop without queued op or result room");

    a_quiet_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.tx_valid) |-> (res.tx_byte == 8'd0))
        else $error("tx_byte set without tx_valid");

    a_tx_code: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.tx_valid) |->
            (res.tx_byte == TX_ALERT || res.tx_byte == TX_IDLE_HIGH ||
             res.tx_byte == TX_IDLE_MID || res.tx_byte == TX_IDLE_LOW ||
             res.tx_byte == TX_BUSY_HIGH || res.tx_byte == TX_BUSY_MID ||
             res.tx_byte == TX_BUSY_LOW))
        else $error("unknown reply byte");

endmodule

FILE: sv/dpc_front.sv
// Front end: accepts event transactions and classifies each into an
// operation for the queue. Depends on dpc_pkg and dpc_if.
module dpc_front (
    dpc_event_if.sink            cmd,
    input  dpc_pkg::cfg_t        cfg_val,
    input  dpc_pkg::queue_status_t q_stat,
    output logic                 push,
    output dpc_pkg::op_t         op
);
    import dpc_pkg::*;

    logic is_dose;

    assign cmd.ready = !q_stat.full;
    assign push      = cmd.valid && !q_stat.full;

    assign is_dose = (cmd.rx_byte != 8'd0) && (cmd.rx_byte <= cfg_val.max_dose);

    always_comb
    begin
        op.data = cmd.rx_byte;
        op.pin  = cmd.button_level;
        case (cmd.command)
            CMD_BYTE:
            begin
                if (is_dose)
                    op.kind = OP_DOSE;
                else if (cmd.rx_byte == RX_STATUS_REQ)
                    op.kind = OP_STATUS;
                else
                    op.kind = OP_NONE;
            end
            CMD_PERIOD: op.kind = OP_PERIOD;
            CMD_DUTY:   op.kind = OP_DUTY;
            CMD_SAMPLE: op.kind = OP_SAMPLE;
            default:    op.kind = OP_NONE;
        endcase
    end

endmodule

FILE: sv/dpc_queue.sv
// Short FIFO of classified operations between front and back end.
// Depends on dpc_pkg.
module dpc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dpc_pkg::op_t           push_op,
    input  logic                   pop,
    output dpc_pkg::op_t           head_op,
    output dpc_pkg::queue_status_t q_stat,
    output logic [dpc_pkg::QUEUE_CNT_W-1:0] count
);
    import dpc_pkg::*;

    op_t                    entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign q_stat.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_op      = entries_reg[rd_ptr_reg];
    assign count        = count_reg;

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_op;
    end

endmodule

FILE: sv/dpc_back.sv
// Back end: executes queued operations against reservoir, period count,
// pump drive and debounce state; holds the result register.
// Depends on dpc_pkg and dpc_if.
module dpc_back #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dpc_pkg::cfg_t          cfg_val,
    input  dpc_pkg::op_t           op,
    input  dpc_pkg::queue_status_t q_stat,
    output logic                   pop,
    dpc_result_if.source           res
);
    import dpc_pkg::*;

    localparam int PROD_W = LEVEL_W + PPU_W;
    localparam int SUM_W  = PERIOD_WIDTH + 1;

    logic [LEVEL_W-1:0]      reservoir_reg,    reservoir_next;
    logic [PERIOD_WIDTH-1:0] periods_left_reg, periods_left_next;
    logic                    pump_drive_reg,   pump_drive_next;
    logic                    button_state_reg, button_state_next;
    logic [DEB_W-1:0]        differ_count_reg, differ_count_next;
    logic                    res_valid_reg,    res_valid_next;
    logic                    tx_valid_reg,     tx_valid_next;
    logic [7:0]              tx_byte_reg,      tx_byte_next;
    logic                    pump_on_reg,      pump_on_next;

    logic                    load;
    logic [LEVEL_W-1:0]      rx_ext;
    logic [LEVEL_W-1:0]      dose;
    logic [PROD_W-1:0]       product;
    logic [SUM_W-1:0]        sum;
    logic [7:0]              status;
    logic [DEB_W-1:0]        need;
    logic [DEB_W-1:0]        diff_new;

    assign load = !q_stat.empty && (!res_valid_reg || res.ready);
    assign pop  = load;

    assign rx_ext  = LEVEL_W'(op.data);
    assign dose    = (rx_ext <= reservoir_reg) ? rx_ext : reservoir_reg;
    assign product = PROD_W'(dose) * PROD_W'(cfg_val.periods_per_unit);
    assign sum     = SUM_W'(periods_left_reg) + SUM_W'(product);

    always_comb
    begin
        if (periods_left_reg != '0)
        begin
            if (reservoir_reg < cfg_val.empty_band)
                status = TX_BUSY_LOW;
            else if (reservoir_reg < cfg_val.mid_band)
                status = TX_BUSY_MID;
            else
                status = TX_BUSY_HIGH;
        end
        else
        begin
            if (reservoir_reg < cfg_val.empty_band)
                status = TX_IDLE_LOW;
            else if (reservoir_reg < cfg_val.mid_band)
                status = TX_IDLE_MID;
            else
                status = TX_IDLE_HIGH;
        end
    end

    assign need = (cfg_val.debounce_samples == '0) ? DEB_W'(1)
                  : cfg_val.debounce_samples;

    always_comb
    begin
        if (op.pin != button_state_reg)
            diff_new = (differ_count_reg == '1) ? '1 : differ_count_reg + 1'b1;
        else
            diff_new = '0;
    end

    always_comb
    begin
        reservoir_next    = reservoir_reg;
        periods_left_next = periods_left_reg;
        pump_drive_next   = pump_drive_reg;
        button_state_next = button_state_reg;
        differ_count_next = differ_count_reg;
        res_valid_next    = res_valid_reg && !res.ready;
        tx_valid_next     = tx_valid_reg;
        tx_byte_next      = tx_byte_reg;
        pump_on_next      = pump_on_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
            tx_valid_next  = 1'b0;
            tx_byte_next   = 8'd0;
            case (op.kind)
                OP_DOSE:
                begin
                    if (reservoir_reg <= cfg_val.alert_level)
                    begin
                        tx_valid_next = 1'b1;
                        tx_byte_next  = TX_ALERT;
                    end
                    reservoir_next    = reservoir_reg - dose;
                    periods_left_next = sum[SUM_W-1] ? '1 : sum[PERIOD_WIDTH-1:0];
                end
                OP_STATUS:
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = status;
                end
                OP_PERIOD:
                begin
                    if (periods_left_reg != '0)
                    begin
                        pump_drive_next   = 1'b1;
                        periods_left_next = periods_left_reg - 1'b1;
                    end
                end
                OP_DUTY:
                    pump_drive_next = 1'b0;
                OP_SAMPLE:
                begin
                    differ_count_next = diff_new;
                    if (diff_new >= need)
                    begin
                        differ_count_next = '0;
                        button_state_next = !button_state_reg;
                        if (button_state_reg)
                            reservoir_next = cfg_val.full_level;
                    end
                end
                default:
                    ;
            endcase
            pump_on_next = pump_drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reservoir_reg    <= RST_RESERVOIR;
            periods_left_reg <= '0;
            pump_drive_reg   <= 1'b0;
            button_state_reg <= 1'b1;
            differ_count_reg <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            reservoir_reg    <= reservoir_next;
            periods_left_reg <= periods_left_next;
            pump_drive_reg   <= pump_drive_next;
            button_state_reg <= button_state_next;
            differ_count_reg <= differ_count_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_valid_reg <= tx_valid_next;
        tx_byte_reg  <= tx_byte_next;
        pump_on_reg  <= pump_on_next;
    end

    assign res.valid    = res_valid_reg;
    assign res.tx_valid = tx_valid_reg;
    assign res.tx_byte  = tx_byte_reg;
    assign res.pump_on  = pump_on_reg;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for dose_pump_controller: directed and random event streams with
// random stalls on both channels, checked in order against a predictor of the
// pump state. Depends on dpc_pkg, the dpc_if interfaces and the RTL.
module tb;
    import dpc_pkg::*;

    localparam int PERIOD_BITS = 16;
    localparam int SHOWN_LIMIT = 10;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic       button_level;
    } pump_event_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       pump_on;
    } pump_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dpc_event_if  cmd_ch ();
    dpc_result_if res_ch ();
    dpc_cfg_if    cfg_ch ();

    dose_pump_controller #(.PERIOD_WIDTH(PERIOD_BITS)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    cfg_t                   pump_cfg;
    logic [LEVEL_W-1:0]     reservoir;
    logic [PERIOD_BITS-1:0] periods_left;
    logic                   pump_drive;
    logic                   button_state;
    logic [2:0]             differ_count;

    pump_event_t pending_events[$];
    pump_reply_t expected_replies[$];
    pump_event_t next_event;
    logic        event_taken = 1'b0;
    logic        steady = 1'b0;
    logic        hold_request = 1'b0;
    int          hold_left = 0;
    int          events_queued = 0;
    int          replies_seen = 0;
    int          failures = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] status_reply();
        logic busy;
        busy = (periods_left != '0);
        if (reservoir < pump_cfg.empty_band)
            return busy ? TX_BUSY_LOW : TX_IDLE_LOW;
        if (reservoir < pump_cfg.mid_band)
            return busy ? TX_BUSY_MID : TX_IDLE_MID;
        return busy ? TX_BUSY_HIGH : TX_IDLE_HIGH;
    endfunction

    function automatic pump_reply_t pump_step(pump_event_t ev);
        pump_reply_t          reply;
        logic [LEVEL_W-1:0]   dose;
        logic [PERIOD_BITS:0] total;
        logic [DEB_W-1:0]     need;
        reply = '0;
        case (ev.command)
            CMD_BYTE:
            begin
                if (ev.rx_byte != 8'd0 && ev.rx_byte <= pump_cfg.max_dose)
                begin
                    if (reservoir <= pump_cfg.alert_level)
                    begin
                        reply.tx_valid = 1'b1;
                        reply.tx_byte  = TX_ALERT;
                    end
                    dose = (ev.rx_byte <= reservoir) ? LEVEL_W'(ev.rx_byte) : reservoir;
                    reservoir = reservoir - dose;
                    total = {1'b0, periods_left}
                            + (PERIOD_BITS+1)'(dose * pump_cfg.periods_per_unit);
                    // queued periods saturate
                    periods_left = total[PERIOD_BITS] ? '1 : total[PERIOD_BITS-1:0];
                end
                else if (ev.rx_byte == RX_STATUS_REQ)
                begin
                    reply.tx_valid = 1'b1;
                    reply.tx_byte  = status_reply();
                end
            end
            CMD_PERIOD:
            begin
                if (periods_left != '0)
                begin
                    pump_drive   = 1'b1;
                    periods_left = periods_left - 1'b1;
                end
            end
            CMD_DUTY:
                pump_drive = 1'b0;
            CMD_SAMPLE:
            begin
                need = pump_cfg.debounce_samples;
                if (need == '0)
                    need = DEB_W'(1);
                if (ev.button_level != button_state)
                    differ_count = (differ_count == 3'd7) ? 3'd7 : differ_count + 3'd1;
                else
                    differ_count = 3'd0;
                if (differ_count >= need)
                begin
                    differ_count = 3'd0;
                    button_state = !button_state;
                    if (!button_state)
                        reservoir = pump_cfg.full_level;
                end
            end
        endcase
        reply.pump_on = pump_drive;
        return reply;
    endfunction

    // sample config writes, results and accepted events
    always @(posedge clk)
    begin : watch
        pump_reply_t got;
        pump_reply_t want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_FULL_LEVEL:       pump_cfg.full_level = cfg_ch.data;
                    REG_ALERT_LEVEL:      pump_cfg.alert_level = cfg_ch.data;
                    REG_EMPTY_BAND:       pump_cfg.empty_band = cfg_ch.data;
                    REG_MID_BAND:         pump_cfg.mid_band = cfg_ch.data;
                    REG_MAX_DOSE:         pump_cfg.max_dose = cfg_ch.data[DOSE_W-1:0];
                    REG_PERIODS_PER_UNIT: pump_cfg.periods_per_unit = cfg_ch.data[PPU_W-1:0];
                    REG_DEBOUNCE_SAMPLES: pump_cfg.debounce_samples = cfg_ch.data[DEB_W-1:0];
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got = {res_ch.tx_valid, res_ch.tx_byte, res_ch.pump_on};
                replies_seen++;
                if (expected_replies.size() == 0)
                begin
                    failures++;
                    if (failures <= SHOWN_LIMIT)
                        $display("unexpected transaction: tx_valid %0b tx_byte %02h pump_on %0b",
                                 got.tx_valid, got.tx_byte, got.pump_on);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                        got.pump_on !== want.pump_on)
                    begin
                        failures++;
                        if (failures <= SHOWN_LIMIT)
                            $display("mismatch at transaction %0d: expected %0b/%02h/%0b, got %0b/%02h/%0b",
                                     replies_seen, want.tx_valid, want.tx_byte, want.pump_on,
                                     got.tx_valid, got.tx_byte, got.pump_on);
                    end
                end
            end
            event_taken = cmd_ch.valid && cmd_ch.ready;
            if (event_taken)
                expected_replies.push_back(pump_step({cmd_ch.command, cmd_ch.rx_byte,
                                                      cmd_ch.button_level}));
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!cmd_ch.valid || event_taken))
        begin
            if (pending_events.size() != 0 && (steady || $urandom_range(0, 99) >= 24))
            begin
                next_event = pending_events.pop_front();
                cmd_ch.valid        <= 1'b1;
                cmd_ch.command      <= next_event.command;
                cmd_ch.rx_byte      <= next_event.rx_byte;
                cmd_ch.button_level <= next_event.button_level;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 150;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= steady || $urandom_range(0, 99) >= 24;
        end
    end

    task automatic add_event(input logic [1:0] command, input logic [7:0] rx_byte,
                             input logic pin);
        pending_events.push_back({command, rx_byte, pin});
        events_queued++;
    endtask

    task automatic put_byte(input logic [7:0] rx_byte);
        add_event(CMD_BYTE, rx_byte, 1'($urandom_range(0, 1)));
    endtask

    task automatic put_tick(input logic [1:0] command);
        add_event(command, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic put_sample(input logic pin);
        add_event(CMD_SAMPLE, 8'($urandom_range(0, 255)), pin);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index, input int unsigned value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= reg_index;
        cfg_ch.data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_settings(input int unsigned full, input int unsigned alert,
                                  input int unsigned empty, input int unsigned mid,
                                  input int unsigned max_byte, input int unsigned ppu,
                                  input int unsigned deb);
        write_reg(REG_FULL_LEVEL, full);
        write_reg(REG_ALERT_LEVEL, alert);
        write_reg(REG_EMPTY_BAND, empty);
        write_reg(REG_MID_BAND, mid);
        write_reg(REG_MAX_DOSE, max_byte);
        write_reg(REG_PERIODS_PER_UNIT, ppu);
        write_reg(REG_DEBOUNCE_SAMPLES, deb);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        while (replies_seen != events_queued)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic queue_random(input int count);
        int   goal;
        int   pick;
        int   run;
        logic pin;
        goal = events_queued + count;
        while (events_queued < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                run = $urandom_range(0, 99);
                if (run < 70 && pump_cfg.max_dose != '0)
                    put_byte(8'($urandom_range(1, pump_cfg.max_dose)));
                else if (run < 85)
                    put_byte(RX_STATUS_REQ);
                else
                    put_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 65)
            begin
                run = $urandom_range(1, 6);
                repeat (run)
                begin
                    put_tick(CMD_PERIOD);
                    if ($urandom_range(0, 2) != 0)
                        put_tick(CMD_DUTY);
                end
            end
            else if (pick < 88)
            begin
                // press/release runs, sometimes with a bounce
                pin = 1'($urandom_range(0, 1));
                repeat (2)
                begin
                    run = $urandom_range(1, 8);
                    repeat (run) put_sample(pin);
                    if ($urandom_range(0, 4) == 0)
                        put_sample(!pin);
                    pin = !pin;
                end
            end
            else
                add_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : stimulus
        int i;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = CMD_BYTE;
        cmd_ch.rx_byte      = 8'd0;
        cmd_ch.button_level = 1'b1;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_FULL_LEVEL;
        cfg_ch.data         = '0;

        pump_cfg.full_level       = RST_FULL_LEVEL;
        pump_cfg.alert_level      = RST_ALERT_LEVEL;
        pump_cfg.empty_band       = RST_EMPTY_BAND;
        pump_cfg.mid_band         = RST_MID_BAND;
        pump_cfg.max_dose         = RST_MAX_DOSE;
        pump_cfg.periods_per_unit = RST_PERIODS_PER_UNIT;
        pump_cfg.debounce_samples = RST_DEBOUNCE_SAMPLES;
        reservoir    = RST_RESERVOIR;
        periods_left = '0;
        pump_drive   = 1'b0;
        button_state = 1'b1;
        differ_count = 3'd0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings
        put_byte(RX_STATUS_REQ);
        put_tick(CMD_PERIOD);
        put_byte(8'd0);
        put_byte(RST_MAX_DOSE + 8'd1);
        put_byte(8'hFE);
        put_byte(8'd1);
        put_byte(RST_MAX_DOSE);
        put_byte(RX_STATUS_REQ);
        put_tick(CMD_PERIOD);
        put_tick(CMD_DUTY);
        put_tick(CMD_PERIOD);
        put_sample(1'b0);
        put_sample(1'b0);
        put_sample(1'b1);
        repeat (RST_DEBOUNCE_SAMPLES) put_sample(1'b0);
        repeat (RST_DEBOUNCE_SAMPLES) put_sample(1'b1);
        put_byte(RX_STATUS_REQ);
        settle();

        // status byte taken as a dose, zero refill, zero debounce, nothing queued
        write_settings(0, 2047, 2047, 2047, 255, 0, 0);
        put_byte(RX_STATUS_REQ);
        put_byte(8'd200);
        put_sample(1'b0);
        put_byte(8'd9);
        put_sample(1'b1);
        put_tick(CMD_PERIOD);
        queue_random(150);
        settle();

        write_settings(2047, 0, 0, 0, 1, 7, 7);
        put_byte(RX_STATUS_REQ);
        queue_random(150);
        settle();

        // repeated refills and large doses drive the period count to saturation
        write_settings(2047, 0, 700, 1400, 254, 7, 1);
        repeat (6)
        begin
            put_sample(1'b1);
            put_sample(1'b0);
            repeat (9) put_byte(8'd254);
        end
        put_byte(RX_STATUS_REQ);
        put_tick(CMD_PERIOD);
        put_tick(CMD_DUTY);
        queue_random(150);
        settle();

        for (i = 0; i < 5; i++)
        begin
            write_settings($urandom_range(0, 2047), $urandom_range(0, 2047),
                           $urandom_range(0, 800), $urandom_range(400, 2047),
                           $urandom_range(0, 255), $urandom_range(0, 7), $urandom_range(0, 7));
            steady = (i == 1);
            hold_request = (i == 3);
            queue_random(180);
            settle();
        end
        steady = 1'b0;

        repeat (8) @(negedge clk);
        if (expected_replies.size() != 0)
            failures++;
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
